// ----- rtl/u2a_pkg.sv -----
// ----------------------------------------------------------------------------
// u2a_pkg
// Shared widths, codes, types and the digit character table used by the
// radix to ASCII conversion unit.
// ----------------------------------------------------------------------------
package u2a_pkg;

  localparam int VALUE_WIDTH = 64;

  // Digit counts for each supported radix at VALUE_WIDTH bits.
  localparam int NUM_DEC = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NUM_OCT = (VALUE_WIDTH + 2) / 3;
  localparam int NUM_HEX = (VALUE_WIDTH + 3) / 4;
  localparam int NUM_BIN = VALUE_WIDTH;

  // The digit shift register is sized for the BCD form, the widest one.
  localparam int DIG_W   = 4 * NUM_DEC;
  localparam int OCT_BITS = 3 * NUM_OCT;
  localparam int HEX_BITS = 4 * NUM_HEX;
  localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);

  localparam logic [7:0] RADIX_BIN = 8'd2;
  localparam logic [7:0] RADIX_OCT = 8'd8;
  localparam logic [7:0] RADIX_DEC = 8'd10;
  localparam logic [7:0] RADIX_HEX = 8'd16;

  localparam logic [15:0][7:0] DIGIT_CHARS = "FEDCBA9876543210";

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT
  } state_t;

  // Number of bits that one digit occupies in the shift register.
  typedef enum logic [1:0] {
    DW_1,
    DW_3,
    DW_4
  } dig_mode_t;

  typedef struct packed {
    logic             load;
    logic             unsup;
    dig_mode_t        mode;
    logic [CNT_W-1:0] count;
    logic [DIG_W-1:0] data;
  } emit_load_t;

  typedef struct packed {
    logic active;
  } emit_stat_t;

  typedef struct packed {
    logic done;
  } conv_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    digit_char = DIGIT_CHARS[d];
  endfunction

endpackage

// ----- rtl/u64_radix_to_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// u64_radix_to_ascii_unit
// Radix 16, 8 and 2: the value is loaded into the digit shifter, which then
// scans its digits in turn, one digit at a time, most significant first.
// Radix 10: the bit-serial BCD converter is started and runs over every value
// bit, then its BCD result is loaded into the digit shifter and scanned in turn.
// Busy drops in the cycle after the last character, also for an unsupported radix.
// Results cannot be stalled. Synchronous reset clears the state register and the run, done, active and strobe flags.
// ----------------------------------------------------------------------------
module u64_radix_to_ascii_unit import u2a_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic [7:0]  radix,
  output logic        strobe,
  output logic [7:0]  ascii_char,
  output logic        last,
  output logic        unsupported
);

  state_t                 state;
  state_t                 state_next;
  logic                   accept;
  logic                   conv_start;
  logic [VALUE_WIDTH-1:0] v;
  logic [DIG_W-1:0]       bcd;
  conv_stat_t             conv_stat;
  emit_load_t             ld;
  emit_stat_t             emit_stat;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign v      = value[VALUE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    conv_start = 1'b0;
    ld.load    = 1'b0;
    ld.unsup   = 1'b0;
    ld.mode    = DW_4;
    ld.count   = CNT_W'(NUM_HEX);
    ld.data    = DIG_W'(v) << (DIG_W - HEX_BITS);
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (radix)
            RADIX_DEC: begin
              conv_start = 1'b1;
              state_next = S_CONV;
            end
            RADIX_HEX: begin
              ld.load    = 1'b1;
              state_next = S_EMIT;
            end
            RADIX_OCT: begin
              ld.load    = 1'b1;
              ld.mode    = DW_3;
              ld.count   = CNT_W'(NUM_OCT);
              ld.data    = DIG_W'(v) << (DIG_W - OCT_BITS);
              state_next = S_EMIT;
            end
            RADIX_BIN: begin
              ld.load    = 1'b1;
              ld.mode    = DW_1;
              ld.count   = CNT_W'(NUM_BIN);
              ld.data    = DIG_W'(v) << (DIG_W - VALUE_WIDTH);
              state_next = S_EMIT;
            end
            default: begin
              ld.load    = 1'b1;
              ld.unsup   = 1'b1;
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_CONV: begin
        if (conv_stat.done) begin
          ld.load    = 1'b1;
          ld.count   = CNT_W'(NUM_DEC);
          ld.data    = bcd;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!emit_stat.active) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  u2a_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (conv_start),
    .value (v),
    .bcd   (bcd),
    .stat  (conv_stat)
  );

  u2a_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .ld          (ld),
    .stat        (emit_stat),
    .strobe      (strobe),
    .ascii_char  (ascii_char),
    .last        (last),
    .unsupported (unsupported)
  );

endmodule

// ----- rtl/u2a_dabble.sv -----
// ----------------------------------------------------------------------------
// u2a_dabble
// Bit-serial binary to BCD converter: one value bit enters per cycle, most
// significant first, with an add-three correction on each BCD lane.
// ----------------------------------------------------------------------------
module u2a_dabble import u2a_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] value,
  output logic [DIG_W-1:0]       bcd,
  output conv_stat_t             stat
);

  logic [VALUE_WIDTH-1:0] bin;
  logic [CNT_W-1:0]       cnt;
  logic                   run;
  logic [DIG_W-1:0]       corr;

  always_comb begin
    for (int i = 0; i < NUM_DEC; i++) begin
      if (bcd[4*i +: 4] > 4'd4) begin
        corr[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        corr[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        bin <= value;
        bcd <= '0;
        cnt <= CNT_W'(VALUE_WIDTH);
        run <= 1'b1;
      end else if (run) begin
        bcd <= {corr[DIG_W-2:0], bin[VALUE_WIDTH-1]};
        bin <= bin << 1;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run       <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/u2a_emit.sv -----
// ----------------------------------------------------------------------------
// u2a_emit
// Digit shifter: takes digits off the top of a left-aligned shift register,
// drops leading zeros and, once past them, presents one character per cycle.
// ----------------------------------------------------------------------------
module u2a_emit import u2a_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  emit_load_t ld,
  output emit_stat_t stat,
  output logic       strobe,
  output logic [7:0] ascii_char,
  output logic       last,
  output logic       unsupported
);

  logic [DIG_W-1:0] sr;
  logic [DIG_W-1:0] sr_next;
  dig_mode_t        mode;
  logic [CNT_W-1:0] cnt;
  logic             seen;
  logic [3:0]       dig;
  logic             take;

  always_comb begin
    case (mode)
      DW_1: begin
        dig     = {3'b000, sr[DIG_W-1]};
        sr_next = sr << 1;
      end
      DW_3: begin
        dig     = {1'b0, sr[DIG_W-1 -: 3]};
        sr_next = sr << 3;
      end
      default: begin
        dig     = sr[DIG_W-1 -: 4];
        sr_next = sr << 4;
      end
    endcase
    // The final digit always goes out, which covers a zero value.
    take = (dig != 4'd0) || seen || (cnt == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.active <= 1'b0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (ld.load) begin
        sr   <= ld.data;
        mode <= ld.mode;
        cnt  <= ld.count;
        seen <= 1'b0;
        if (ld.unsup) begin
          strobe      <= 1'b1;
          ascii_char  <= 8'd0;
          last        <= 1'b1;
          unsupported <= 1'b1;
          stat.active <= 1'b0;
        end else begin
          stat.active <= 1'b1;
        end
      end else if (stat.active) begin
        sr  <= sr_next;
        cnt <= cnt - CNT_W'(1);
        if (take) begin
          seen        <= 1'b1;
          strobe      <= 1'b1;
          ascii_char  <= digit_char(dig);
          last        <= (cnt == CNT_W'(1));
          unsupported <= 1'b0;
        end
        if (cnt == CNT_W'(1)) begin
          stat.active <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/u2a_checker.sv -----
// ----------------------------------------------------------------------------
// u2a_checker
// Port-level checks on the conversion unit, attached by a bind statement.
// ----------------------------------------------------------------------------
module u2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [7:0] ascii_char,
  input logic       strobe,
  input logic       last,
  input logic       unsupported
);

  // An unsupported radix yields a single null character.
  a_unsup_form: assert property (@(posedge clk) disable iff (rst)
    strobe && unsupported |-> last && (ascii_char == 8'd0))
    else $error("unsupported result is not a single null character");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe && !unsupported |->
      ((ascii_char >= 8'h30) && (ascii_char <= 8'h39)) ||
      ((ascii_char >= 8'h41) && (ascii_char <= 8'h46)))
    else $error("result character is not an uppercase digit");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // A conversion can only be in flight while the unit is busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("character before the last one while not busy");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !strobe)
    else $error("result directly after a last character");

endmodule

bind u64_radix_to_ascii_unit u2a_checker u_checker (.*);
